### src/ffa_pkg.sv
// Package for the first-fit free-list allocator: sizes, payload structs,
// region RAM request and total update types, sequencer states.
// No dependencies; every other file of the block imports it.
package ffa_pkg;

  localparam int unsigned ENTRIES = 256;
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = IDX_W + 1;
  localparam int unsigned TOT_W   = 32 + IDX_W;

  localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  typedef enum logic [1:0] {
    OUT_OK    = 2'd0,
    OUT_NOFIT = 2'd1,
    OUT_FULL  = 2'd2
  } outcome_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic        round_to_page;
    logic [31:0] region_addr;
    logic [31:0] region_size;
  } ffa_req_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic [1:0]  outcome;
    logic [31:0] free_total;
  } ffa_rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } region_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    region_t          wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic        en;
    logic [31:0] add;
    logic [32:0] sub;
  } tot_upd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_DECIDE,
    ST_RM_RD,
    ST_RM_WR,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_DONE
  } ctrl_state_e;

  function automatic logic [31:0] page_round(input logic [31:0] size);
    page_round = (size + PAGE_ADD) & PAGE_MASK;
  endfunction

endpackage

### src/ffa_region_ram.sv
// Region table storage: one entry of start and length per free region,
// one write and one registered read per cycle. Depends on ffa_pkg.
module ffa_region_ram (
  input  logic              clk_i,
  input  ffa_pkg::ram_req_t ram_req_i,
  output ffa_pkg::region_t  rdata_o
);
  import ffa_pkg::*;

  region_t mem [ENTRIES];
  region_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ram_req_i.we) begin
      mem[ram_req_i.waddr] <= ram_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_req_i.re) begin
      rdata_q <= mem[ram_req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/ffa_total.sv
// Free byte total: exact sum of all region lengths, updated by the
// sequencer, shown saturated to 32 bits. Depends on ffa_pkg.
module ffa_total (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffa_pkg::tot_upd_t tot_upd_i,
  output logic [31:0]       free_total_o
);
  import ffa_pkg::*;

  logic [TOT_W-1:0] sum_q, sum_d;

  // The exact sum never exceeds ENTRIES regions of 32 bits, so modular
  // arithmetic in TOT_W bits gives the true value after each update.
  always_comb begin
    sum_d = sum_q;
    if (tot_upd_i.en) begin
      sum_d = sum_q + TOT_W'(tot_upd_i.add) - TOT_W'(tot_upd_i.sub);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign free_total_o = (|sum_q[TOT_W-1:32]) ? '1 : sum_q[31:0];

endmodule

### src/ffa_ctrl.sv
// Sequencer of the allocator: scans the region RAM, carves, merges,
// removes and inserts entries, and keeps the region count.
// Depends on ffa_pkg; drives ffa_region_ram and ffa_total.
module ffa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ffa_pkg::ffa_req_t in_req_i,
  output logic              done_valid_o,
  input  logic              done_ready_i,
  output logic [31:0]       result_addr_o,
  output logic [1:0]        outcome_o,
  output ffa_pkg::ram_req_t ram_req_o,
  input  ffa_pkg::region_t  ram_rdata_i,
  output ffa_pkg::tot_upd_t tot_upd_o
);
  import ffa_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] kk_q, kk_d;
  logic             cmd_q, cmd_d;
  logic [31:0]      addr_q, addr_d;
  logic [31:0]      size_q, size_d;
  region_t          prev_q, prev_d;
  region_t          cur_q, cur_d;
  logic             prev_vld_q, prev_vld_d;
  logic             cur_vld_q, cur_vld_d;
  logic [31:0]      res_addr_q, res_addr_d;
  outcome_e         outcome_q, outcome_d;

  logic [CNT_W-1:0] idx_p1, idx_m1, kk_m1;
  logic             alloc_fit, alloc_empty, scan_last, free_stop;
  logic             prev_touch, next_touch, table_full;
  logic [31:0]      end_addr, merge_len, next_len;

  assign idx_p1 = idx_q + CNT_W'(1);
  assign idx_m1 = idx_q - CNT_W'(1);
  assign kk_m1  = kk_q - CNT_W'(1);

  assign alloc_fit   = ram_rdata_i.length >= size_q;
  assign alloc_empty = ram_rdata_i.length == size_q;
  assign scan_last   = idx_p1 == cnt_q;
  assign free_stop   = ram_rdata_i.start > addr_q;

  assign end_addr   = addr_q + size_q;
  assign prev_touch = prev_vld_q && ((prev_q.start + prev_q.length) == addr_q);
  assign next_touch = cur_vld_q && (cur_q.start == end_addr);
  assign table_full = cnt_q >= CNT_W'(ENTRIES - 1);
  assign merge_len  = prev_q.length + size_q + (next_touch ? cur_q.length : 32'd0);
  assign next_len   = cur_q.length + size_q;

  // Next state and register updates.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    kk_d       = kk_q;
    cmd_d      = cmd_q;
    addr_d     = addr_q;
    size_d     = size_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    prev_vld_d = prev_vld_q;
    cur_vld_d  = cur_vld_q;
    res_addr_d = res_addr_q;
    outcome_d  = outcome_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d      = in_req_i.cmd;
          addr_d     = in_req_i.region_addr;
          size_d     = in_req_i.round_to_page ? page_round(in_req_i.region_size)
                                              : in_req_i.region_size;
          idx_d      = '0;
          prev_vld_d = 1'b0;
          cur_vld_d  = 1'b0;
          res_addr_d = '0;
          outcome_d  = OUT_OK;
          if (cnt_q == '0) begin
            if (in_req_i.cmd == CMD_ALLOC) begin
              outcome_d = OUT_NOFIT;
              state_d   = ST_DONE;
            end else begin
              state_d = ST_DECIDE;
            end
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (cmd_q == CMD_ALLOC) begin
          if (alloc_fit) begin
            res_addr_d = ram_rdata_i.start;
            state_d    = alloc_empty ? ST_RM_RD : ST_DONE;
          end else if (scan_last) begin
            outcome_d = OUT_NOFIT;
            state_d   = ST_DONE;
          end else begin
            idx_d   = idx_p1;
            state_d = ST_RD;
          end
        end else begin
          if (free_stop) begin
            cur_d     = ram_rdata_i;
            cur_vld_d = 1'b1;
            state_d   = ST_DECIDE;
          end else begin
            prev_d     = ram_rdata_i;
            prev_vld_d = 1'b1;
            idx_d      = idx_p1;
            state_d    = scan_last ? ST_DECIDE : ST_RD;
          end
        end
      end
      ST_DECIDE: begin
        if (prev_touch) begin
          state_d = next_touch ? ST_RM_RD : ST_DONE;
        end else if (next_touch) begin
          state_d = ST_DONE;
        end else if (table_full) begin
          outcome_d = OUT_FULL;
          state_d   = ST_DONE;
        end else begin
          kk_d    = cnt_q;
          state_d = (cnt_q == idx_q) ? ST_INS_PUT : ST_INS_RD;
        end
      end
      ST_RM_RD: begin
        if (idx_p1 < cnt_q) begin
          state_d = ST_RM_WR;
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = ST_DONE;
        end
      end
      ST_RM_WR: begin
        idx_d   = idx_p1;
        state_d = ST_RM_RD;
      end
      ST_INS_RD: begin
        state_d = ST_INS_WR;
      end
      ST_INS_WR: begin
        kk_d    = kk_m1;
        state_d = (kk_m1 == idx_q) ? ST_INS_PUT : ST_INS_RD;
      end
      ST_INS_PUT: begin
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (done_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // RAM accesses, total updates and handshake outputs.
  always_comb begin
    ram_req_o  = '0;
    tot_upd_o  = '0;
    in_ready_o = 1'b0;
    done_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = idx_q[IDX_W-1:0];
      end
      ST_CHK: begin
        if (cmd_q == CMD_ALLOC && alloc_fit) begin
          tot_upd_o.en  = 1'b1;
          tot_upd_o.sub = {1'b0, size_q};
          if (!alloc_empty) begin
            ram_req_o.we           = 1'b1;
            ram_req_o.waddr        = idx_q[IDX_W-1:0];
            ram_req_o.wdata.start  = ram_rdata_i.start + size_q;
            ram_req_o.wdata.length = ram_rdata_i.length - size_q;
          end
        end
      end
      ST_DECIDE: begin
        if (prev_touch) begin
          ram_req_o.we           = 1'b1;
          ram_req_o.waddr        = idx_m1[IDX_W-1:0];
          ram_req_o.wdata.start  = prev_q.start;
          ram_req_o.wdata.length = merge_len;
          tot_upd_o.en  = 1'b1;
          tot_upd_o.add = merge_len;
          tot_upd_o.sub = {1'b0, prev_q.length} +
                          {1'b0, (next_touch ? cur_q.length : 32'd0)};
        end else if (next_touch) begin
          ram_req_o.we           = 1'b1;
          ram_req_o.waddr        = idx_q[IDX_W-1:0];
          ram_req_o.wdata.start  = addr_q;
          ram_req_o.wdata.length = next_len;
          tot_upd_o.en  = 1'b1;
          tot_upd_o.add = next_len;
          tot_upd_o.sub = {1'b0, cur_q.length};
        end else if (!table_full) begin
          tot_upd_o.en  = 1'b1;
          tot_upd_o.add = size_q;
        end
      end
      ST_RM_RD: begin
        if (idx_p1 < cnt_q) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_p1[IDX_W-1:0];
        end
      end
      ST_RM_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = idx_q[IDX_W-1:0];
        ram_req_o.wdata = ram_rdata_i;
      end
      ST_INS_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = kk_m1[IDX_W-1:0];
      end
      ST_INS_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = kk_q[IDX_W-1:0];
        ram_req_o.wdata = ram_rdata_i;
      end
      ST_INS_PUT: begin
        ram_req_o.we           = 1'b1;
        ram_req_o.waddr        = idx_q[IDX_W-1:0];
        ram_req_o.wdata.start  = addr_q;
        ram_req_o.wdata.length = size_q;
      end
      ST_DONE: begin
        done_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign result_addr_o = res_addr_q;
  assign outcome_o     = outcome_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    kk_q       <= kk_d;
    cmd_q      <= cmd_d;
    addr_q     <= addr_d;
    size_q     <= size_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    prev_vld_q <= prev_vld_d;
    cur_vld_q  <= cur_vld_d;
    res_addr_q <= res_addr_d;
    outcome_q  <= outcome_d;
  end

endmodule

### src/first_fit_free_list_allocator.sv
// An allocate on an empty table fails with no fit without reading the RAM;
// else it scans up to the first fit and, if that region empties, shifts the
// later entries down. A free scans up to its place, then merges with one or
// both neighbors or shifts the later entries up to insert its region.
// A new request is taken in the cycle after the response is registered.
// Reset clears the region count and the free total; RAM contents are left.
module first_fit_free_list_allocator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ffa_pkg::ffa_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ffa_pkg::ffa_rsp_t out_rsp_o
);
  import ffa_pkg::*;

  ram_req_t    ram_req;
  region_t     ram_rdata;
  tot_upd_t    tot_upd;
  logic [31:0] free_total;
  logic        done_valid, done_ready;
  logic [31:0] result_addr;
  logic [1:0]  outcome;

  logic        out_valid_q, out_valid_d;
  ffa_rsp_t    out_rsp_q, out_rsp_d;

  ffa_region_ram u_ram (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rdata_o   (ram_rdata)
  );

  ffa_total u_total (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tot_upd_i    (tot_upd),
    .free_total_o (free_total)
  );

  ffa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_req_i      (in_req_i),
    .done_valid_o  (done_valid),
    .done_ready_i  (done_ready),
    .result_addr_o (result_addr),
    .outcome_o     (outcome),
    .ram_req_o     (ram_req),
    .ram_rdata_i   (ram_rdata),
    .tot_upd_o     (tot_upd)
  );

  // The output register frees the sequencer to take the next request
  // while a finished response waits for the consumer.
  assign done_ready = done_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    if (done_ready) begin
      out_valid_d           = 1'b1;
      out_rsp_d.result_addr = result_addr;
      out_rsp_d.outcome     = outcome;
      out_rsp_d.free_total  = free_total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

### src/ffa_checker.sv
// Port-level checks for the allocator, attached to the top level by bind.
// Depends on ffa_pkg and first_fit_free_list_allocator.
module ffa_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input ffa_pkg::ffa_req_t in_req_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ffa_pkg::ffa_rsp_t out_rsp_o
);
  import ffa_pkg::*;

  logic [1:0] pend_q, pend_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // At most one request in the sequencer and one in the output register.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more requests outstanding than the block can hold");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("response without an outstanding request");

  a_outcome_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.outcome != OUT_OK |->
      out_rsp_o.result_addr == 32'd0 &&
      (out_rsp_o.outcome == OUT_NOFIT || out_rsp_o.outcome == OUT_FULL))
    else $error("failed response carries an address or an unknown outcome");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (.*);
